// ----- rtl/lru_key_value_cache_unit_macros.svh -----
// Assertion macros used by the checker of the key-value cache.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lkvc_pkg.sv -----
// Package of the LRU key-value cache: sizes, register map and the
// structs passed between the top level and the tag array. No dependencies.
package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 16;
	localparam int SLOT_BITS  = $clog2(ENTRIES);
	localparam int COUNT_BITS = $clog2(ENTRIES + 1);
	localparam int CAP_BITS   = 5;
	localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	localparam int APB_DATA_BITS = 32;
	localparam int PADDR_BITS    = 3;
	localparam int REG_IDX_BITS  = PADDR_BITS - 2;
	localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY = REG_IDX_BITS'(0);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Operation handed to the tag array for the item under lookup.
	typedef struct packed {
		logic active;
		logic put;
	} lkvc_op_t;

	// Lookup outcome and value memory request for that item.
	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic [KEY_BITS-1:0]  evicted_key;
		logic                 mem_read;
		logic                 mem_write;
		logic [SLOT_BITS-1:0] mem_slot;
	} lkvc_look_t;

endpackage

// ----- rtl/lkvc_ifs.sv -----
// Valid/ready channel interfaces for cache requests and responses.
// Depends on lkvc_pkg for field widths.
interface lkvc_req_if;
	import lkvc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;
	modport source (output valid, cmd, lookup_key, write_value, input ready);
	modport sink (input valid, cmd, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
	import lkvc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;
	logic [KEY_BITS-1:0]   evicted_key;
	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ----- rtl/lkvc_value_ram.sv -----
// Single-port value memory with a registered read, one entry per slot.
// Depends on lkvc_pkg.
module lkvc_value_ram (
	input  logic                            clk,
	input  logic                            we,
	input  logic                            re,
	input  logic [lkvc_pkg::SLOT_BITS-1:0]  addr,
	input  logic [lkvc_pkg::VALUE_BITS-1:0] wdata,
	output logic [lkvc_pkg::VALUE_BITS-1:0] rdata
);
	import lkvc_pkg::*;

	logic [VALUE_BITS-1:0] mem [ENTRIES];
	logic [VALUE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/lkvc_tag_array.sv -----
// Key tags, valid bits, recency ranks and entry count of the cache.
// Compares all tags in parallel, picks the victim and applies the update.
// Depends on lkvc_pkg.
module lkvc_tag_array (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvc_pkg::lkvc_op_t            op,
	input  logic [lkvc_pkg::KEY_BITS-1:0] key,
	input  logic [lkvc_pkg::CAP_BITS-1:0] capacity,
	output lkvc_pkg::lkvc_look_t          look
);
	import lkvc_pkg::*;

	logic [KEY_BITS-1:0]   key_q   [ENTRIES];
	logic [SLOT_BITS-1:0]  rank_q  [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [ENTRIES-1:0]   match;
	logic [ENTRIES-1:0]   oldest;
	logic                 hit;
	logic [SLOT_BITS-1:0] hit_slot;
	logic [SLOT_BITS-1:0] victim_slot;
	logic [SLOT_BITS-1:0] free_slot;
	logic [SLOT_BITS-1:0] new_slot;
	logic [SLOT_BITS-1:0] last_rank;
	logic [CMP_BITS-1:0]  cap_w;
	logic [CMP_BITS-1:0]  eff_cap;
	logic                 need_evict;
	logic                 insert;
	logic                 evict;

	always_comb begin
		cap_w = CMP_BITS'(capacity);
		if (cap_w == '0) begin
			eff_cap = CMP_BITS'(1);
		end else if (cap_w > CMP_BITS'(ENTRIES)) begin
			eff_cap = CMP_BITS'(ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
		need_evict = (CMP_BITS'(count_q) >= eff_cap) && (count_q != '0);
		last_rank  = SLOT_BITS'(count_q - COUNT_BITS'(1));
	end

	// Ranks of valid slots are always 0 .. count-1, so the victim is the one
	// valid slot whose rank equals count-1 and keys never match twice.
	always_comb begin
		hit_slot    = '0;
		victim_slot = '0;
		free_slot   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key);
			oldest[i] = valid_q[i] && (rank_q[i] == last_rank);
			if (match[i]) begin
				hit_slot = SLOT_BITS'(i);
			end
			if (oldest[i]) begin
				victim_slot = SLOT_BITS'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_BITS'(i);
			end
		end
		hit      = |match;
		insert   = op.active && op.put && !hit;
		evict    = insert && need_evict;
		new_slot = need_evict ? victim_slot : free_slot;

		look.hit         = hit;
		look.evicted     = evict;
		look.evicted_key = evict ? key_q[victim_slot] : '0;
		look.mem_read    = op.active && !op.put && hit;
		look.mem_write   = op.active && op.put;
		look.mem_slot    = hit ? hit_slot : new_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (op.active) begin
			if (hit) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] < rank_q[hit_slot])) begin
						rank_q[i] <= rank_q[i] + SLOT_BITS'(1);
					end
				end
				rank_q[hit_slot] <= '0;
			end else if (insert) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && !(evict && (SLOT_BITS'(i) == victim_slot))) begin
						rank_q[i] <= rank_q[i] + SLOT_BITS'(1);
					end
				end
				rank_q[new_slot]  <= '0;
				valid_q[new_slot] <= 1'b1;
				if (!need_evict) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			key_q[new_slot] <= key;
		end
	end
endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// LRU key-value cache, 16 entries, 16-bit keys and values.
// An accepted item passes state S_LOOK (tag lookup and update with the value memory
// access) and then S_DONE, which loads the response once the output register is free;
// the next item can be accepted as that response is loaded, while responses are taken.
// Reset empties the cache at once through the valid bits and sets capacity to 16.
// Depends on lkvc_pkg, lkvc_ifs, lkvc_tag_array and lkvc_value_ram.
module lru_key_value_cache_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	lkvc_req_if.sink                           req,
	lkvc_rsp_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lkvc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [lkvc_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [lkvc_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import lkvc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_DONE = 3'b100
	} lkvc_state_t;

	lkvc_state_t state_q, state_d;

	logic [CAP_BITS-1:0]     capacity_q;
	logic [REG_IDX_BITS-1:0] reg_idx;

	logic                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;

	logic                hit_s1;
	logic                put_s1;
	logic                evicted_s1;
	logic [KEY_BITS-1:0] evicted_key_s1;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [VALUE_BITS-1:0] out_read_value_q;
	logic                  out_evicted_q;
	logic [KEY_BITS-1:0]   out_evicted_key_q;

	lkvc_op_t              op;
	lkvc_look_t            look;
	logic [VALUE_BITS-1:0] ram_rdata;
	logic                  load_out;
	logic                  accept;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CAPACITY) begin
			prdata = APB_DATA_BITS'(capacity_q);
		end
	end

	// Sequencer: accept, look up and update tags, then collect the value.
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE) || load_out;
	assign accept    = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = accept ? S_LOOK : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			key_q  <= req.lookup_key;
			wval_q <= req.write_value;
		end
	end

	assign op.active = (state_q == S_LOOK);
	assign op.put    = (cmd_q == CMD_PUT);

	lkvc_tag_array u_tags (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.key      (key_q),
		.capacity (capacity_q),
		.look     (look)
	);

	lkvc_value_ram u_values (
		.clk   (clk),
		.we    (look.mem_write),
		.re    (look.mem_read),
		.addr  (look.mem_slot),
		.wdata (wval_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (op.active) begin
			hit_s1         <= look.hit;
			put_s1         <= op.put;
			evicted_s1     <= look.evicted;
			evicted_key_s1 <= look.evicted_key;
		end
	end

	// Output register: the next item may be accepted while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q         <= hit_s1;
			out_read_value_q  <= (hit_s1 && !put_s1) ? ram_rdata : '0;
			out_evicted_q     <= evicted_s1;
			out_evicted_key_q <= evicted_key_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_read_value_q;
	assign rsp.evicted     = out_evicted_q;
	assign rsp.evicted_key = out_evicted_key_q;
endmodule

// ----- rtl/lkvc_checker.sv -----
// Port-level checks of the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_unit_macros.svh.
`include "lru_key_value_cache_unit_macros.svh"

module lkvc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            hit,
	input logic [lkvc_pkg::VALUE_BITS-1:0] read_value,
	input logic                            evicted,
	input logic [lkvc_pkg::KEY_BITS-1:0]   evicted_key
);
	import lkvc_pkg::*;

	// A stalled response keeps its contents.
	`LKVC_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(read_value) && $stable(evicted) && $stable(evicted_key), "stalled response changed")

	// Each item occupies the lookup state, so no two are taken back to back.
	`LKVC_ASSERT_NEXT(a_spacing, in_valid && in_ready, !in_ready, "items accepted in consecutive cycles")

	// Only a get that hits returns a value.
	`LKVC_ASSERT_NOW(a_miss_zero, out_valid && !hit, read_value == '0, "value returned without a hit")

	// Eviction comes only from a put miss and carries a key only then.
	`LKVC_ASSERT_NOW(a_evict, out_valid, (!evicted || !hit) && (evicted || (evicted_key == '0)), "inconsistent eviction report")
endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.hit         (rsp.hit),
	.read_value  (rsp.read_value),
	.evicted     (rsp.evicted),
	.evicted_key (rsp.evicted_key)
);
